/* src/spq_pkg.sv */
// Package: shared constants, request/result types and cell control for the sorted queue.
package spq_pkg;

  localparam int QueueDepth = 16;
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int TagW       = 16;
  localparam int PrioW      = 16;
  localparam int CountOutW  = 5;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef struct packed {
    mode_t                    mode;
    logic [TagW-1:0]          task_tag;
    logic signed [PrioW-1:0]  task_priority;
  } in_req_t;

  typedef struct packed {
    logic                     head_valid;
    logic [TagW-1:0]          head_tag;
    logic signed [PrioW-1:0]  head_priority;
    logic [TagW-1:0]          popped_tag;
    logic [CountOutW-1:0]     entry_count;
    err_t                     error_code;
  } out_res_t;

  typedef struct packed {
    logic [TagW-1:0]          tag;
    logic signed [PrioW-1:0]  prio;
  } spq_entry_t;

  // Broadcast to every cell in the chain for one request.
  typedef struct packed {
    logic       push;
    logic       pop;
    spq_entry_t ent;
  } spq_cell_ctrl_t;

endpackage

/* src/spq_cell.sv */
// Module: one slot of the sorted chain, holding a tag and priority.
module spq_cell (
  input  logic                    clk,
  input  spq_pkg::spq_cell_ctrl_t ctrl,
  input  logic                    occ,
  input  logic                    prev_keep,
  input  spq_pkg::spq_entry_t     prev_ent,
  input  spq_pkg::spq_entry_t     next_ent,
  output logic                    keep,
  output spq_pkg::spq_entry_t     ent,
  output spq_pkg::spq_entry_t     ent_nxt
);

  spq_pkg::spq_entry_t ent_r;

  // Stay put while this slot outranks the incoming entry.
  assign keep = occ && (ent_r.prio > ctrl.ent.prio);

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.push) begin
      if (!keep) begin
        ent_nxt = prev_keep ? ctrl.ent : prev_ent;
      end
    end else if (ctrl.pop) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

/* src/sorted_priority_queue.sv */
// Top level: sorted priority queue built from a chain of compare-and-shift cells.
//
// Usage:
//   Present a request on in_req and raise start; it is taken at the rising
//   edge where start is high and busy is low. busy stays low, so one request
//   is taken every cycle. A push (mode MODE_PUSH) inserts task_tag behind all
//   entries of strictly higher priority, ahead of equal ones; a pop
//   (MODE_POP) removes the head. A push when full or a pop when empty leaves
//   the queue untouched and reports ERR_FULL or ERR_EMPTY.
//   Each request yields one result on out_res, marked by out_valid for
//   exactly one cycle, the cycle after the request was taken.
//   The result shows the head, count and popped tag after the operation.
//   Throughput is one request per cycle: every cell compares its own
//   priority with the new one and shifts, all cells in parallel.
//   The receiver cannot stall; results must be captured when out_valid is
//   high. Synchronous reset (rst_n low) empties the queue and drops any
//   pending result strobe; slot contents are not cleared.
module sorted_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::in_req_t  in_req,
  output logic              out_valid,
  output spq_pkg::out_res_t out_res
);

  localparam int Depth = spq_pkg::QueueDepth;
  localparam int CntW  = spq_pkg::CntW;

  logic [CntW-1:0]         count_r, count_nxt;
  logic                    out_valid_r;
  spq_pkg::out_res_t       out_res_r, out_res_nxt;
  spq_pkg::spq_cell_ctrl_t ctrl;
  spq_pkg::err_t           err;

  logic                    accept;
  logic                    full, empty;
  logic [Depth-1:0]        occ;
  logic [Depth-1:0]        keep;
  spq_pkg::spq_entry_t     ent     [Depth];
  spq_pkg::spq_entry_t     ent_nxt [Depth];
  logic [CntW+spq_pkg::CountOutW-1:0] count_wide;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CntW'(Depth));
  assign empty  = (count_r == '0);

  // Decide the operation; rejected requests leave the chain alone.
  always_comb begin
    ctrl.ent.tag  = in_req.task_tag;
    ctrl.ent.prio = in_req.task_priority;
    ctrl.push     = 1'b0;
    ctrl.pop      = 1'b0;
    err           = spq_pkg::ERR_OK;
    count_nxt     = count_r;
    if (accept) begin
      unique case (in_req.mode)
        spq_pkg::MODE_PUSH: begin
          if (full) begin
            err = spq_pkg::ERR_FULL;
          end else begin
            ctrl.push = 1'b1;
            count_nxt = count_r + CntW'(1);
          end
        end
        spq_pkg::MODE_POP: begin
          if (empty) begin
            err = spq_pkg::ERR_EMPTY;
          end else begin
            ctrl.pop  = 1'b1;
            count_nxt = count_r - CntW'(1);
          end
        end
        default: err = spq_pkg::ERR_OK;
      endcase
    end
  end

  // Build the chain; slot i holds an entry while the count exceeds i.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::spq_entry_t prev_ent, next_ent;
    logic                prev_keep;

    assign occ[i] = (count_r > CntW'(i));

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign prev_ent  = ctrl.ent;
    end else begin : g_body
      assign prev_keep = keep[i-1];
      assign prev_ent  = ent[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_ent = ent[i];
    end else begin : g_mid
      assign next_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[i]),
      .prev_keep (prev_keep),
      .prev_ent  (prev_ent),
      .next_ent  (next_ent),
      .keep      (keep[i]),
      .ent       (ent[i]),
      .ent_nxt   (ent_nxt[i])
    );
  end

  assign count_wide = {{spq_pkg::CountOutW{1'b0}}, count_nxt};

  // Assemble the result from the post-operation head of the chain.
  always_comb begin
    out_res_nxt.head_valid    = (count_nxt != '0);
    out_res_nxt.head_tag      = (count_nxt != '0) ? ent_nxt[0].tag  : '0;
    out_res_nxt.head_priority = (count_nxt != '0) ? ent_nxt[0].prio : '0;
    out_res_nxt.popped_tag    = ctrl.pop ? ent[0].tag : '0;
    out_res_nxt.entry_count   = count_wide[spq_pkg::CountOutW-1:0];
    out_res_nxt.error_code    = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Hold the result payload without reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Count never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("queue count beyond depth");

  // Every taken request gives a strobe in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("missing result strobe");

  // A rejected request leaves the count untouched.
  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && err != spq_pkg::ERR_OK) |=> (count_r == $past(count_r)))
    else $error("rejected request changed the queue");

  // Reported head validity agrees with the reported count.
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.head_valid == (count_r != '0)))
    else $error("head valid disagrees with count");

  // The first two occupied slots stay in descending priority order.
  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    occ[1] |-> (ent[0].prio >= ent[1].prio))
    else $error("head slots out of order");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the sorted priority queue: directed and random requests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomRequests = 1450;
  localparam int ReportLimit    = 10;
  localparam int QueueDepth     = spq_pkg::QueueDepth;
  localparam int TagW           = spq_pkg::TagW;
  localparam int PrioW          = spq_pkg::PrioW;
  localparam int CountOutW      = spq_pkg::CountOutW;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  spq_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  spq_pkg::out_res_t out_res;

  // Shadow copy of the queue contents, head at slot 0.
  logic [TagW-1:0]         shadow_tag  [QueueDepth];
  logic signed [PrioW-1:0] shadow_prio [QueueDepth];
  int                      shadow_fill = 0;

  // Results still owed by the block, oldest first.
  spq_pkg::out_res_t pending_results[$];

  bit gaps_on = 1'b1;
  int mismatches = 0;
  int requests_sent = 0;
  int push_count = 0;
  int pop_count = 0;
  int full_rejects = 0;
  int empty_rejects = 0;
  int results_seen = 0;
  int deepest_fill = 0;

  sorted_priority_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Apply one request to the shadow queue and return the result it should give.
  function automatic spq_pkg::out_res_t apply_request(spq_pkg::in_req_t req);
    spq_pkg::out_res_t res;
    int pos;
    int i;
    res = '0;
    res.error_code = spq_pkg::ERR_OK;
    if (req.mode == spq_pkg::MODE_PUSH) begin
      push_count++;
      if (shadow_fill >= QueueDepth) begin
        res.error_code = spq_pkg::ERR_FULL;
        full_rejects++;
      end else begin
        // Walk past every entry of strictly higher priority; ties go in front.
        pos = 0;
        while (pos < shadow_fill && $signed(shadow_prio[pos]) > $signed(req.task_priority))
          pos++;
        for (i = shadow_fill; i > pos; i--) begin
          shadow_tag[i]  = shadow_tag[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_tag[pos]  = req.task_tag;
        shadow_prio[pos] = req.task_priority;
        shadow_fill++;
      end
    end else begin
      pop_count++;
      if (shadow_fill == 0) begin
        res.error_code = spq_pkg::ERR_EMPTY;
        empty_rejects++;
      end else begin
        res.popped_tag = shadow_tag[0];
        for (i = 1; i < shadow_fill; i++) begin
          shadow_tag[i-1]  = shadow_tag[i];
          shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_fill--;
      end
    end
    if (shadow_fill > 0) begin
      res.head_valid    = 1'b1;
      res.head_tag      = shadow_tag[0];
      res.head_priority = shadow_prio[0];
    end
    res.entry_count = shadow_fill[CountOutW-1:0];
    if (shadow_fill > deepest_fill)
      deepest_fill = shadow_fill;
    return res;
  endfunction

  // Present one request, optionally after an idle gap, and hold it until taken.
  task automatic send_request(input spq_pkg::in_req_t req);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    // Advance until an edge at which busy was low: that edge takes the request.
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(req));
    requests_sent++;
  endtask

  function automatic spq_pkg::in_req_t make_push(logic [TagW-1:0] tag,
                                                 logic signed [PrioW-1:0] prio);
    spq_pkg::in_req_t req;
    req.mode          = spq_pkg::MODE_PUSH;
    req.task_tag      = tag;
    req.task_priority = prio;
    return req;
  endfunction

  function automatic spq_pkg::in_req_t make_pop(logic [TagW-1:0] noise_tag,
                                                logic signed [PrioW-1:0] noise_prio);
    spq_pkg::in_req_t req;
    req.mode          = spq_pkg::MODE_POP;
    req.task_tag      = noise_tag;
    req.task_priority = noise_prio;
    return req;
  endfunction

  // Pop on an empty queue, then a queue of one entry taken in and out again.
  task automatic test_empty_and_single();
    send_request(make_pop(16'h0000, 16'sh0000));
    send_request(make_push(16'hBEEF, -16'sd5));
    send_request(make_pop(16'h1234, 16'sh7FFF));
    // Pop fields carry all-ones noise; they must be ignored.
    send_request(make_pop(16'hFFFF, -16'sd1));
  endtask

  // Fill to the brim with ties and extreme priorities, then push once more.
  task automatic test_fill_and_overflow();
    logic [TagW-1:0]         tags  [16];
    logic signed [PrioW-1:0] prios [16];
    tags  = '{16'hFFFF, 16'h0000, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'hA5A5,
              16'h5A5A, 16'h8001, 16'h7FFE, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 16'h6666};
    prios = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh8000,
              -16'sd1, 16'sd1, 16'sh8001, 16'sh7FFE, 16'sd1, -16'sd1, 16'sh5555,
              16'shAAAA, 16'sh0000};
    for (int i = 0; i < 16; i++)
      send_request(make_push(tags[i], prios[i]));
    // Highest possible priority still bounces off a full queue.
    send_request(make_push(16'hFFFF, 16'sh7FFF));
  endtask

  // Take a few entries off the head; newest of the top tie comes out first.
  task automatic test_head_pops();
    repeat (3) send_request(make_pop(16'($urandom), 16'($urandom)));
  endtask

  // Random traffic in segments, each with its own push bias and priority style.
  task automatic test_random_traffic();
    int seg_len;
    int push_pct;
    int style;
    logic signed [PrioW-1:0] prio;
    logic signed [PrioW-1:0] extremes [4];
    int done;
    extremes = '{16'sh8000, 16'sh7FFF, 16'sh8001, 16'sh7FFE};
    done = 0;
    while (done < RandomRequests) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 25;
        1: push_pct = 50;
        default: push_pct = 80;
      endcase
      style = $urandom_range(0, 2);
      // Roughly one segment in four runs back to back with no idle cycles.
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (seg_len) begin
        case (style)
          0: prio = 16'($urandom);
          1: prio = 16'($signed($urandom_range(0, 3)) - 2);   // crowd into ties
          default: prio = extremes[$urandom_range(0, 3)];
        endcase
        if ($urandom_range(1, 100) <= push_pct)
          send_request(make_push(16'($urandom), prio));
        else
          send_request(make_pop(16'($urandom), prio));
        done++;
      end
    end
    gaps_on = 1'b1;
  endtask

  // Compare every strobed result with the oldest owed one, field by field.
  always @(posedge clk) begin
    spq_pkg::out_res_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: result with no request outstanding: %p", $realtime, out_res);
      end else begin
        want = pending_results.pop_front();
        if (out_res.head_valid !== want.head_valid ||
            out_res.head_tag !== want.head_tag ||
            out_res.head_priority !== want.head_priority ||
            out_res.popped_tag !== want.popped_tag ||
            out_res.entry_count !== want.entry_count ||
            out_res.error_code !== want.error_code) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected valid=%0b head=%h prio=%0d popped=%h count=%0d err=%s",
                     want.head_valid, want.head_tag, want.head_priority, want.popped_tag,
                     want.entry_count, want.error_code.name());
            $display("  actual   valid=%0b head=%h prio=%0d popped=%h count=%0d err=%0d",
                     out_res.head_valid, out_res.head_tag, out_res.head_priority,
                     out_res.popped_tag, out_res.entry_count, out_res.error_code);
          end
        end
      end
    end
  end

  // Main sequence: reset, directed requests, random traffic, drain, verdict.
  initial begin
    int guard;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_single();
    test_fill_and_overflow();
    test_head_pops();
    test_random_traffic();

    start <= 1'b0;
    // Wait for the last owed result, then let the pipeline settle.
    guard = 0;
    while (pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", pending_results.size());
    end

    $display("Sent %0d requests (%0d pushes, %0d pops), checked %0d results",
             requests_sent, push_count, pop_count, results_seen);
    $display("Rejected %0d pushes when full and %0d pops when empty; deepest fill %0d of %0d",
             full_rejects, empty_rejects, deepest_fill, QueueDepth);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Timed out waiting for the block");
    $display("Test completed with failures");
    $finish;
  end

endmodule
